[hdl/seven_segment_scan_controller_assert.svh]
// Assertion macros for the seven-segment scan controller.
`ifndef SEVEN_SEGMENT_SCAN_CONTROLLER_ASSERT_SVH
`define SEVEN_SEGMENT_SCAN_CONTROLLER_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define SSC_ASSERT_AT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SSC_ASSERT(label, prop, msg) \
  `SSC_ASSERT_AT(label, clk_i, rst_ni, prop, msg)
`else
`define SSC_ASSERT_AT(label, clk, rst_n, prop, msg)
`define SSC_ASSERT(label, prop, msg)
`endif

`endif

[hdl/ssc_pkg.sv]
// Shared types, codes and the character table of the scan controller.
`default_nettype none

package ssc_pkg;

  localparam int CFG_W = 4;
  localparam int CODE_W = 6;
  localparam int GLYPH_COUNT = 41;
  localparam logic [CODE_W-1:0] BLANK_CODE = 6'd13;

  typedef enum logic [2:0] {
    KIND_REFRESH = 3'd0,
    KIND_BLINK   = 3'd1,
    KIND_SCROLL  = 3'd2,
    KIND_START   = 3'd3,
    KIND_WRITE   = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_SCROLL = 2'd1,
    MODE_BLINK  = 2'd2,
    MODE_STATIC = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    REG_MODE        = 3'd0,
    REG_BRIGHTNESS  = 3'd1,
    REG_TAIL_VIEW   = 3'd2,
    REG_START_INDEX = 3'd3,
    REG_BLINK_MASK  = 3'd4
  } reg_e;

  localparam logic [1:0] BRIGHT_LOW  = 2'd0;
  localparam logic [1:0] BRIGHT_MED  = 2'd1;
  localparam logic [1:0] BRIGHT_HIGH = 2'd2;

  typedef struct packed {
    logic [2:0]        kind;
    logic [3:0]        position;
    logic [CODE_W-1:0] char_code;
    logic [4:0]        msg_len;
  } in_t;

  typedef struct packed {
    logic [1:0] digit_select;
    logic [7:0] segments;
  } out_t;

  typedef struct packed {
    mode_e      mode;
    logic [1:0] brightness;
    logic       tail_view;
    logic [3:0] start_index;
    logic [3:0] blink_mask;
  } cfg_t;

  localparam logic [7:0] GLYPHS [GLYPH_COUNT] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h67,
    8'h40, 8'h08, 8'h80, 8'h00,
    8'h77, 8'h5F, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h7B, 8'h71, 8'h7D, 8'h6F,
    8'h76, 8'h74, 8'h06, 8'h1F, 8'h1E, 8'h06, 8'h38, 8'h37,
    8'h3F, 8'h73, 8'hBF, 8'h33, 8'h6D, 8'h78, 8'h3E, 8'h75, 8'h6E
  };

  function automatic logic [7:0] glyph_of(input logic [CODE_W-1:0] code);
    logic [7:0] seg;
    seg = 8'h00;
    if (int'(code) < GLYPH_COUNT) begin
      seg = GLYPHS[code];
    end
    return seg;
  endfunction

endpackage

`default_nettype wire

[hdl/ssc_cfg_regs.sv]
// Configuration registers of the scan controller.
`default_nettype none

module ssc_cfg_regs #(
  parameter int BUF_DEPTH = 16,
  parameter int DIGITS = 4
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic [2:0]               cfg_index_i,
  input  wire logic [ssc_pkg::CFG_W-1:0] cfg_wdata_i,
  output ssc_pkg::cfg_t                 cfg_o,
  output logic                          mode_wr_o
);

  ssc_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    mode_wr_o = 1'b0;
    if (cfg_we_i) begin
      case (cfg_index_i)
        ssc_pkg::REG_MODE: begin
          cfg_d.mode = ssc_pkg::mode_e'(cfg_wdata_i[1:0]);
          mode_wr_o = 1'b1;
        end
        ssc_pkg::REG_BRIGHTNESS: begin
          // drop the unused level
          if (cfg_wdata_i[1:0] <= ssc_pkg::BRIGHT_HIGH) begin
            cfg_d.brightness = cfg_wdata_i[1:0];
          end
        end
        ssc_pkg::REG_TAIL_VIEW: begin
          cfg_d.tail_view = cfg_wdata_i[0];
        end
        ssc_pkg::REG_START_INDEX: begin
          if (int'(cfg_wdata_i) < BUF_DEPTH - DIGITS) begin
            cfg_d.start_index = cfg_wdata_i;
          end
        end
        ssc_pkg::REG_BLINK_MASK: begin
          cfg_d.blink_mask = cfg_wdata_i;
        end
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode        <= ssc_pkg::MODE_CLEAR;
      cfg_q.brightness  <= ssc_pkg::BRIGHT_MED;
      cfg_q.tail_view   <= 1'b0;
      cfg_q.start_index <= 4'd0;
      cfg_q.blink_mask  <= 4'd0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

[hdl/ssc_msg_store.sv]
// Message store: character codes with per-entry valid bits, bulk clear to blank.
`default_nettype none

module ssc_msg_store #(
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       clear_i,
  input  wire logic                       we_i,
  input  wire logic [ADDR_W-1:0]          waddr_i,
  input  wire logic [ssc_pkg::CODE_W-1:0] wdata_i,
  input  wire logic [ADDR_W-1:0]          raddr_i,
  output logic [ssc_pkg::CODE_W-1:0]      rdata_o
);

  logic [DEPTH-1:0]           valid_q;
  logic [ssc_pkg::CODE_W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (clear_i) begin
      valid_q <= '0;
    end else if (we_i) begin
      valid_q[waddr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // an entry not written since the last clear reads blank
  assign rdata_o = valid_q[raddr_i] ? mem_q[raddr_i] : ssc_pkg::BLANK_CODE;

endmodule

`default_nettype wire

[hdl/ssc_scan_core.sv]
// Scan state, window and scroll arithmetic, and segment lookup for one beat.
`default_nettype none

module ssc_scan_core #(
  parameter int BUF_DEPTH = 16,
  parameter int DIGITS = 4
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           fire_i,
  input  wire ssc_pkg::in_t   item_i,
  input  wire ssc_pkg::cfg_t  cfg_i,
  input  wire logic           mode_wr_i,
  output ssc_pkg::out_t       result_o
);

  localparam int LEN_W  = $clog2(BUF_DEPTH + 1);
  localparam int ADDR_W = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam int DIG_W  = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam int SUM_W  = (LEN_W + 1 > 5) ? LEN_W + 1 : 5;
  // a long message has length + 1 >= DIGITS + 2, so this many subtracts
  // bring any kept scroll position below it
  localparam int REM_PASSES = BUF_DEPTH / (DIGITS + 2);

  logic [LEN_W-1:0] len_q, len_d;
  logic [LEN_W-1:0] scroll_q, scroll_d;
  logic [LEN_W-1:0] rem_q, rem_d;
  logic [DIG_W-1:0] digit_q, digit_d;
  logic [1:0]       frame_q, frame_d;
  logic             blink_q, blink_d;

  logic is_refresh, is_blink, is_scroll, is_start, is_write;
  logic lit, blink_off;
  logic [7:0]       d_ext;
  logic [SUM_W-1:0] d_sum, len_ext, win, sum, wrap, slot;
  logic [LEN_W-1:0] sat_len;
  logic [LEN_W-1:0] start_rem;
  logic [ssc_pkg::CODE_W-1:0] rd_code, code;
  logic store_clear, store_we;

  assign is_refresh = fire_i && (item_i.kind == ssc_pkg::KIND_REFRESH);
  assign is_blink   = fire_i && (item_i.kind == ssc_pkg::KIND_BLINK);
  assign is_scroll  = fire_i && (item_i.kind == ssc_pkg::KIND_SCROLL);
  assign is_start   = fire_i && (item_i.kind == ssc_pkg::KIND_START);
  assign is_write   = fire_i && (item_i.kind == ssc_pkg::KIND_WRITE);

  always_comb begin
    case (cfg_i.brightness)
      ssc_pkg::BRIGHT_LOW:  lit = (frame_q == 2'd0);
      ssc_pkg::BRIGHT_MED:  lit = ~frame_q[0];
      default:              lit = 1'b1;
    endcase
  end

  assign d_ext   = 8'(digit_q);
  assign d_sum   = SUM_W'(digit_q);
  assign len_ext = SUM_W'(len_q);

  always_comb begin
    if (cfg_i.tail_view) begin
      win = (int'(len_q) > DIGITS) ? len_ext - SUM_W'(DIGITS) : '0;
    end else begin
      win = SUM_W'(cfg_i.start_index);
    end
  end

  // rem_q is the scroll position reduced modulo length + 1
  assign sum  = SUM_W'(rem_q) + d_sum;
  assign wrap = len_ext + SUM_W'(1);

  always_comb begin
    if (cfg_i.mode == ssc_pkg::MODE_SCROLL) begin
      if (int'(len_q) <= DIGITS) begin
        slot = d_sum;
      end else begin
        slot = (sum >= wrap) ? sum - wrap : sum;
      end
    end else begin
      slot = win + d_sum;
    end
  end

  ssc_msg_store #(
    .DEPTH(BUF_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (store_clear),
    .we_i    (store_we),
    .waddr_i (ADDR_W'(item_i.position)),
    .wdata_i (item_i.char_code),
    .raddr_i (slot[ADDR_W-1:0]),
    .rdata_o (rd_code)
  );

  assign code = (slot < len_ext) ? rd_code : ssc_pkg::BLANK_CODE;

  assign blink_off = (cfg_i.mode == ssc_pkg::MODE_BLINK) && blink_q &&
                     (d_ext < 8'd4) && cfg_i.blink_mask[d_ext[1:0]];

  always_comb begin
    result_o.digit_select = d_ext[1:0];
    result_o.segments = 8'h00;
    if (lit && (cfg_i.mode != ssc_pkg::MODE_CLEAR) && !blink_off) begin
      result_o.segments = ssc_pkg::glyph_of(code);
    end
  end

  assign store_we = is_write && (int'(item_i.position) < BUF_DEPTH);
  assign store_clear = is_start ||
                       (is_refresh && lit && (cfg_i.mode == ssc_pkg::MODE_CLEAR));

  assign sat_len = (int'(item_i.msg_len) > BUF_DEPTH) ? LEN_W'(BUF_DEPTH)
                                                       : LEN_W'(item_i.msg_len);

  // fold the kept scroll position against the new length
  always_comb begin
    start_rem = scroll_q;
    for (int i = 0; i < REM_PASSES; i++) begin
      if (start_rem > sat_len) begin
        start_rem = start_rem - sat_len - LEN_W'(1);
      end
    end
  end

  always_comb begin
    len_d    = len_q;
    scroll_d = scroll_q;
    rem_d    = rem_q;
    digit_d  = digit_q;
    frame_d  = frame_q;
    blink_d  = blink_q;

    if (is_start) begin
      len_d = sat_len;
    end else if (is_refresh && lit && (cfg_i.mode == ssc_pkg::MODE_CLEAR)) begin
      len_d = '0;
    end

    if (is_refresh) begin
      if (digit_q == DIG_W'(DIGITS - 1)) begin
        digit_d = '0;
        frame_d = frame_q + 2'd1;
      end else begin
        digit_d = digit_q + DIG_W'(1);
      end
    end

    if (mode_wr_i) begin
      scroll_d = '0;
      rem_d    = '0;
      blink_d  = 1'b0;
    end else begin
      if (is_blink && (cfg_i.mode == ssc_pkg::MODE_BLINK)) begin
        blink_d = ~blink_q;
      end
      if (is_scroll && (cfg_i.mode == ssc_pkg::MODE_SCROLL)) begin
        scroll_d = (scroll_q >= len_q) ? '0 : scroll_q + LEN_W'(1);
        rem_d    = scroll_d;
      end else if (is_start) begin
        rem_d = start_rem;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q    <= '0;
      scroll_q <= '0;
      rem_q    <= '0;
      digit_q  <= '0;
      frame_q  <= 2'd0;
      blink_q  <= 1'b0;
    end else begin
      len_q    <= len_d;
      scroll_q <= scroll_d;
      rem_q    <= rem_d;
      digit_q  <= digit_d;
      frame_q  <= frame_d;
      blink_q  <= blink_d;
    end
  end

endmodule

`default_nettype wire

[hdl/seven_segment_scan_controller.sv]
// Top level of the seven-segment scan controller: input and result registers.
//
//   port group  dir  handshake                  payload
//   in          in   in_valid_i / in_stall_o    in_data_i  (ssc_pkg::in_t)
//   out         out  out_valid_o / out_stall_i  out_data_o (ssc_pkg::out_t)
//   cfg         in   cfg_we_i                   cfg_index_i, cfg_wdata_i
//
// One beat per cycle unless in_stall_o is high; a taken beat is held in the input
// register and then updates the core state. A refresh result is loaded into the
// result register as its beat leaves the input register, so it passes both registers.
// Reset is immediate: store entries read blank through valid bits, no clearing pass.
// A stalled result holds; the input register still takes non-refresh beats, and a
// refresh beat waits there, stalling the input, until the result register frees.
`default_nettype none
`include "seven_segment_scan_controller_assert.svh"

module seven_segment_scan_controller #(
  parameter int BUF_DEPTH = 16,
  parameter int DIGITS = 4
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [2:0]                cfg_index_i,
  input  wire logic [ssc_pkg::CFG_W-1:0] cfg_wdata_i,
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire ssc_pkg::in_t              in_data_i,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output ssc_pkg::out_t                  out_data_o
);

  ssc_pkg::cfg_t       cfg;
  ssc_pkg::out_t       result;
  logic                mode_wr;

  logic          in_q_valid_q, in_q_valid_d;
  ssc_pkg::in_t  in_q;
  logic          out_valid_q, out_valid_d;
  ssc_pkg::out_t out_q;

  logic in_accept, out_free, s2_refresh, s2_fire, s2_scan, clear_scan;

  ssc_cfg_regs #(
    .BUF_DEPTH(BUF_DEPTH),
    .DIGITS(DIGITS)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg),
    .mode_wr_o   (mode_wr)
  );

  ssc_scan_core #(
    .BUF_DEPTH(BUF_DEPTH),
    .DIGITS(DIGITS)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (s2_fire),
    .item_i    (in_q),
    .cfg_i     (cfg),
    .mode_wr_i (mode_wr),
    .result_o  (result)
  );

  assign s2_refresh = in_q.kind == ssc_pkg::KIND_REFRESH;
  assign out_free   = !out_valid_q || !out_stall_i;
  // only a refresh beat needs room in the result register
  assign s2_fire    = in_q_valid_q && (!s2_refresh || out_free);
  assign s2_scan    = s2_fire && s2_refresh;
  assign clear_scan = s2_scan && (cfg.mode == ssc_pkg::MODE_CLEAR);
  assign in_stall_o = in_q_valid_q && !s2_fire;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    in_q_valid_d = in_q_valid_q;
    if (in_accept) begin
      in_q_valid_d = 1'b1;
    end else if (s2_fire) begin
      in_q_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (s2_scan) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_q_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      in_q_valid_q <= in_q_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_q <= in_data_i;
    end
    if (s2_scan) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `SSC_ASSERT(a_no_overwrite, (out_valid_o && out_stall_i) |-> !s2_scan, "result overwritten")
  `SSC_ASSERT(a_valid_from_refresh, $rose(out_valid_o) |-> $past(s2_scan), "valid without a scan")
  `SSC_ASSERT(a_clear_blank, clear_scan |=> (out_data_o.segments == 8'h00), "clear mode not blank")

endmodule

`default_nettype wire

[dv/seven_segment_scan_controller_tb.sv]
// Self-checking testbench for the seven-segment scan controller.
`default_nettype none

module testbench;

  localparam int BUF_DEPTH = 16;
  localparam int DIGITS = 4;
  localparam int IN_W = $bits(ssc_pkg::in_t);
  localparam int RANDOM_BEATS = 1000;
  localparam int SETTLE_CYCLES = 16;
  localparam int TIMEOUT = 4000000;

  localparam logic [2:0] KIND_UNUSED_LO = 3'd5;
  localparam logic [2:0] KIND_UNUSED_HI = 3'd7;
  localparam logic [2:0] REG_UNKNOWN_LO = 3'd5;
  localparam logic [2:0] REG_UNKNOWN_HI = 3'd7;
  localparam logic [1:0] BRIGHT_INVALID = 2'd3;

  typedef struct {
    bit            is_reg;
    logic [2:0]    reg_idx;
    logic [3:0]    reg_val;
    ssc_pkg::in_t  beat;
    bit            typed;
    ssc_pkg::out_t want;
  } step_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          cfg_we = 1'b0;
  logic [2:0]    cfg_index = '0;
  logic [3:0]    cfg_wdata = '0;
  logic          in_valid = 1'b0;
  ssc_pkg::in_t  in_data = '0;
  logic          out_stall = 1'b0;
  logic          in_stall_o;
  logic          out_valid_o;
  ssc_pkg::out_t out_data_o;

  // predicted state of the display
  logic [5:0]     msg_store [BUF_DEPTH];
  logic [4:0]     msg_length;
  logic [1:0]     digit_ctr;
  logic [1:0]     frame_ctr;
  logic [4:0]     scroll_pos;
  logic           blink_ph;
  ssc_pkg::mode_e cur_mode;
  logic [1:0]     cur_bright;
  logic           cur_tail_view;
  logic [3:0]     cur_start;
  logic [3:0]     cur_mask;

  ssc_pkg::out_t pending_scans [$];
  step_t         plan [$];
  bit            calm = 1'b0;
  int            mismatches = 0;
  int            beats_sent = 0;
  int            scans_seen = 0;
  int            reg_writes = 0;

  seven_segment_scan_controller u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_data_o  (out_data_o)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #(TIMEOUT);
    $display("Regression FAIL");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  function automatic void wipe_store();
    for (int i = 0; i < BUF_DEPTH; i++) msg_store[i] = ssc_pkg::BLANK_CODE;
  endfunction

  function automatic logic [7:0] glyph_at(input int slot);
    int code;
    if (slot >= int'(msg_length) || slot >= BUF_DEPTH) code = ssc_pkg::BLANK_CODE;
    else code = msg_store[slot];
    return (code < ssc_pkg::GLYPH_COUNT) ? ssc_pkg::GLYPHS[code] : 8'h00;
  endfunction

  function automatic int window_first();
    if (cur_tail_view) return (msg_length > DIGITS) ? int'(msg_length) - DIGITS : 0;
    return cur_start;
  endfunction

  function automatic void apply_reg(input logic [2:0] idx, input logic [3:0] val);
    case (idx)
      ssc_pkg::REG_MODE: begin
        cur_mode = ssc_pkg::mode_e'(val[1:0]);
        scroll_pos = '0;
        blink_ph = 1'b0;
      end
      ssc_pkg::REG_BRIGHTNESS: if (val[1:0] <= ssc_pkg::BRIGHT_HIGH) cur_bright = val[1:0];
      ssc_pkg::REG_TAIL_VIEW: cur_tail_view = val[0];
      ssc_pkg::REG_START_INDEX: if (int'(val) < BUF_DEPTH - DIGITS) cur_start = val;
      ssc_pkg::REG_BLINK_MASK: cur_mask = val;
      default: ;
    endcase
  endfunction

  function automatic void predict_scan(input ssc_pkg::in_t b, output bit made,
                                       output ssc_pkg::out_t res);
    int period;
    int slot;
    logic [7:0] seg;
    made = 1'b0;
    res = '0;
    seg = 8'h00;
    case (b.kind)
      ssc_pkg::KIND_BLINK: if (cur_mode == ssc_pkg::MODE_BLINK) blink_ph = ~blink_ph;
      ssc_pkg::KIND_SCROLL: begin
        if (cur_mode == ssc_pkg::MODE_SCROLL) begin
          scroll_pos = scroll_pos + 5'd1;
          if (scroll_pos > msg_length) scroll_pos = '0;
        end
      end
      ssc_pkg::KIND_START: begin
        wipe_store();
        msg_length = (int'(b.msg_len) > BUF_DEPTH) ? 5'(BUF_DEPTH) : b.msg_len;
      end
      ssc_pkg::KIND_WRITE: msg_store[b.position] = b.char_code;
      ssc_pkg::KIND_REFRESH: begin
        period = 4 >> cur_bright;
        if (int'(frame_ctr) % period == 0) begin
          case (cur_mode)
            ssc_pkg::MODE_SCROLL: begin
              if (msg_length <= DIGITS) slot = digit_ctr;
              else slot = (int'(scroll_pos) + int'(digit_ctr)) % (int'(msg_length) + 1);
              seg = glyph_at(slot);
            end
            ssc_pkg::MODE_BLINK: begin
              if (blink_ph && cur_mask[digit_ctr]) seg = 8'h00;
              else seg = glyph_at(window_first() + int'(digit_ctr));
            end
            ssc_pkg::MODE_STATIC: seg = glyph_at(window_first() + int'(digit_ctr));
            default: begin
              wipe_store();
              msg_length = '0;
              seg = 8'h00;
            end
          endcase
        end
        res.digit_select = digit_ctr;
        res.segments = seg;
        made = 1'b1;
        if (int'(digit_ctr) == DIGITS - 1) begin
          digit_ctr = '0;
          frame_ctr = frame_ctr + 2'd1;
        end else begin
          digit_ctr = digit_ctr + 2'd1;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic step_t row_reg(input logic [2:0] idx, input logic [3:0] val);
    step_t s;
    s = '{is_reg: 1'b1, reg_idx: idx, reg_val: val, beat: '0, typed: 1'b0, want: '0};
    return s;
  endfunction

  function automatic step_t row_beat(input logic [2:0] kind, input logic [3:0] pos,
                                     input logic [5:0] code, input logic [4:0] len,
                                     input bit typed, input ssc_pkg::out_t want);
    step_t s;
    s = '{is_reg: 1'b0, reg_idx: '0, reg_val: '0, beat: '0, typed: typed, want: want};
    s.beat.kind = kind;
    s.beat.position = pos;
    s.beat.char_code = code;
    s.beat.msg_len = len;
    return s;
  endfunction

  // hold valid until taken; leave it high when the next beat follows at once
  task automatic send_beat(input ssc_pkg::in_t b, input bit typed,
                           input ssc_pkg::out_t want);
    bit made;
    ssc_pkg::out_t res;
    int gap;
    in_valid <= 1'b1;
    in_data <= b;
    @(posedge clk);
    while (in_stall_o) @(posedge clk);
    predict_scan(b, made, res);
    if (made) pending_scans.push_back(typed ? want : res);
    if (b.kind <= ssc_pkg::KIND_WRITE) beats_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // drop valid and wait until every scan is back and the block has gone quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_scans.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [3:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    apply_reg(idx, val);
    reg_writes++;
    @(posedge clk);
  endtask

  // result side: random stall stretches
  initial begin
    int n;
    @(posedge clk);
    forever begin
      n = pick_gap();
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    ssc_pkg::out_t want;
    if (rst_n && out_valid_o && !out_stall) begin
      scans_seen++;
      if (pending_scans.size() == 0) begin
        $display("%0t: unexpected scan beat: digit_select %0d segments %02h",
                 $time, out_data_o.digit_select, out_data_o.segments);
        mismatches++;
      end else begin
        want = pending_scans.pop_front();
        if (out_data_o.digit_select !== want.digit_select) begin
          $display("%0t: digit_select expected %0d, got %0d",
                   $time, want.digit_select, out_data_o.digit_select);
          mismatches++;
        end
        if (out_data_o.segments !== want.segments) begin
          $display("%0t: segments expected %02h, got %02h",
                   $time, want.segments, out_data_o.segments);
          mismatches++;
        end
      end
    end
  end

  initial begin
    int ph;
    int n;
    int r;
    int len;
    int directed;
    bit writing;
    ssc_pkg::in_t b;
    ssc_pkg::mode_e pick;

    cur_mode = ssc_pkg::MODE_CLEAR;
    cur_bright = ssc_pkg::BRIGHT_MED;
    cur_tail_view = 1'b0;
    cur_start = '0;
    cur_mask = '0;
    wipe_store();
    msg_length = '0;
    digit_ctr = '0;
    frame_ctr = '0;
    scroll_pos = '0;
    blink_ph = 1'b0;

    plan.push_back(row_beat(ssc_pkg::KIND_REFRESH, 4'd0, 6'd0, 5'd0, 1'b1,
                            ssc_pkg::out_t'{2'd0, 8'h00}));
    plan.push_back(row_reg(ssc_pkg::REG_BRIGHTNESS, {2'b00, ssc_pkg::BRIGHT_HIGH}));
    plan.push_back(row_reg(ssc_pkg::REG_MODE, {2'b00, ssc_pkg::MODE_STATIC}));
    plan.push_back(row_beat(ssc_pkg::KIND_START, 4'd15, 6'd63, 5'd31, 1'b0, '0));
    plan.push_back(row_beat(ssc_pkg::KIND_WRITE, 4'd0, 6'd0, 5'd0, 1'b0, '0));
    plan.push_back(row_beat(ssc_pkg::KIND_WRITE, 4'd1, 6'd63, 5'd31, 1'b0, '0));
    plan.push_back(row_beat(ssc_pkg::KIND_WRITE, 4'd2, 6'd40, 5'd0, 1'b0, '0));
    plan.push_back(row_beat(ssc_pkg::KIND_WRITE, 4'd15, 6'd34, 5'd31, 1'b0, '0));
    plan.push_back(row_beat(ssc_pkg::KIND_REFRESH, 4'd0, 6'd0, 5'd0, 1'b1,
                            ssc_pkg::out_t'{2'd1, 8'h00}));
    plan.push_back(row_beat(ssc_pkg::KIND_REFRESH, 4'd15, 6'd63, 5'd31, 1'b1,
                            ssc_pkg::out_t'{2'd2, 8'h6E}));
    plan.push_back(row_beat(ssc_pkg::KIND_REFRESH, 4'd0, 6'd0, 5'd0, 1'b1,
                            ssc_pkg::out_t'{2'd3, 8'h00}));
    plan.push_back(row_beat(ssc_pkg::KIND_REFRESH, 4'd0, 6'd0, 5'd0, 1'b1,
                            ssc_pkg::out_t'{2'd0, 8'h3F}));
    plan.push_back(row_reg(ssc_pkg::REG_TAIL_VIEW, 4'd1));
    plan.push_back(row_beat(ssc_pkg::KIND_REFRESH, 4'd0, 6'd0, 5'd0, 1'b0, '0));
    plan.push_back(row_beat(ssc_pkg::KIND_REFRESH, 4'd0, 6'd0, 5'd0, 1'b0, '0));
    plan.push_back(row_beat(ssc_pkg::KIND_REFRESH, 4'd0, 6'd0, 5'd0, 1'b1,
                            ssc_pkg::out_t'{2'd3, 8'hBF}));
    plan.push_back(row_reg(ssc_pkg::REG_START_INDEX, 4'd12));
    plan.push_back(row_reg(ssc_pkg::REG_START_INDEX, 4'd11));
    plan.push_back(row_reg(ssc_pkg::REG_TAIL_VIEW, 4'd0));
    plan.push_back(row_reg(ssc_pkg::REG_BRIGHTNESS, {2'b11, BRIGHT_INVALID}));
    plan.push_back(row_reg(ssc_pkg::REG_MODE, {2'b10, ssc_pkg::MODE_BLINK}));
    plan.push_back(row_reg(ssc_pkg::REG_BLINK_MASK, 4'hF));
    plan.push_back(row_reg(REG_UNKNOWN_HI, 4'hF));
    plan.push_back(row_beat(ssc_pkg::KIND_BLINK, 4'd0, 6'd0, 5'd0, 1'b0, '0));
    plan.push_back(row_beat(ssc_pkg::KIND_REFRESH, 4'd0, 6'd0, 5'd0, 1'b1,
                            ssc_pkg::out_t'{2'd0, 8'h00}));
    plan.push_back(row_beat(KIND_UNUSED_LO, 4'd15, 6'd63, 5'd31, 1'b0, '0));
    plan.push_back(row_beat(KIND_UNUSED_HI, 4'd15, 6'd63, 5'd31, 1'b0, '0));
    plan.push_back(row_reg(ssc_pkg::REG_MODE, {2'b00, ssc_pkg::MODE_SCROLL}));
    plan.push_back(row_beat(ssc_pkg::KIND_SCROLL, 4'd0, 6'd0, 5'd0, 1'b0, '0));
    plan.push_back(row_beat(ssc_pkg::KIND_REFRESH, 4'd0, 6'd0, 5'd0, 1'b0, '0));
    plan.push_back(row_beat(ssc_pkg::KIND_START, 4'd0, 6'd0, 5'd3, 1'b0, '0));
    plan.push_back(row_beat(ssc_pkg::KIND_REFRESH, 4'd0, 6'd0, 5'd0, 1'b0, '0));
    plan.push_back(row_reg(ssc_pkg::REG_BRIGHTNESS, {2'b00, ssc_pkg::BRIGHT_LOW}));
    plan.push_back(row_reg(ssc_pkg::REG_MODE, {2'b00, ssc_pkg::MODE_CLEAR}));
    plan.push_back(row_beat(ssc_pkg::KIND_REFRESH, 4'd0, 6'd0, 5'd0, 1'b0, '0));
    plan.push_back(row_beat(ssc_pkg::KIND_REFRESH, 4'd0, 6'd0, 5'd0, 1'b0, '0));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    writing = 1'b0;
    foreach (plan[i]) begin
      if (plan[i].is_reg) begin
        if (!writing) settle();
        writing = 1'b1;
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        if (writing) cfg_we <= 1'b0;
        writing = 1'b0;
        send_beat(plan[i].beat, plan[i].typed, plan[i].want);
      end
    end
    directed = beats_sent;

    ph = 0;
    while (beats_sent < directed + RANDOM_BEATS) begin
      settle();
      calm = (ph % 4 == 2);
      if (ph == 0) begin
        write_reg(ssc_pkg::REG_MODE, 4'h0);
        write_reg(ssc_pkg::REG_BRIGHTNESS, 4'h0);
        write_reg(ssc_pkg::REG_TAIL_VIEW, 4'h0);
        write_reg(ssc_pkg::REG_START_INDEX, 4'h0);
        write_reg(ssc_pkg::REG_BLINK_MASK, 4'h0);
      end else if (ph == 1) begin
        write_reg(ssc_pkg::REG_MODE, 4'hF);
        write_reg(ssc_pkg::REG_BRIGHTNESS, 4'hE);
        write_reg(ssc_pkg::REG_TAIL_VIEW, 4'hF);
        write_reg(ssc_pkg::REG_START_INDEX, 4'hF);
        write_reg(ssc_pkg::REG_START_INDEX, 4'hB);
        write_reg(ssc_pkg::REG_BLINK_MASK, 4'hF);
      end else begin
        r = $urandom_range(0, 9);
        pick = (r == 0) ? ssc_pkg::MODE_CLEAR :
               (r < 4)  ? ssc_pkg::MODE_SCROLL :
               (r < 7)  ? ssc_pkg::MODE_BLINK : ssc_pkg::MODE_STATIC;
        write_reg(ssc_pkg::REG_MODE, {2'($urandom), pick});
        write_reg(ssc_pkg::REG_BRIGHTNESS, 4'($urandom));
        write_reg(ssc_pkg::REG_TAIL_VIEW, 4'($urandom));
        write_reg(ssc_pkg::REG_START_INDEX, 4'($urandom));
        write_reg(ssc_pkg::REG_BLINK_MASK, 4'($urandom));
        if ($urandom_range(0, 4) == 0)
          write_reg(3'($urandom_range(REG_UNKNOWN_LO, REG_UNKNOWN_HI)), 4'($urandom));
      end
      cfg_we <= 1'b0;

      // load a fresh message, then scan it with ticks mixed in
      r = $urandom_range(0, 9);
      len = (r == 0) ? $urandom_range(17, 31) : (r == 1) ? $urandom_range(0, 4)
                                              : $urandom_range(5, 16);
      b = ssc_pkg::in_t'(IN_W'($urandom));
      b.kind = ssc_pkg::KIND_START;
      b.msg_len = 5'(len);
      send_beat(b, 1'b0, '0);
      for (int p = 0; p < len && p < BUF_DEPTH; p++) begin
        b = ssc_pkg::in_t'(IN_W'($urandom));
        b.kind = ssc_pkg::KIND_WRITE;
        b.position = 4'(p);
        b.char_code = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(41, 63))
                                                   : 6'($urandom_range(0, 40));
        send_beat(b, 1'b0, '0);
      end

      n = $urandom_range(15, 45);
      repeat (n) begin
        if ($urandom_range(0, 39) == 0) settle();
        b = ssc_pkg::in_t'(IN_W'($urandom));
        r = $urandom_range(0, 99);
        if (r < 60) b.kind = ssc_pkg::KIND_REFRESH;
        else if (r < 70) b.kind = (cur_mode == ssc_pkg::MODE_SCROLL) ? ssc_pkg::KIND_SCROLL
                                                                     : ssc_pkg::KIND_BLINK;
        else if (r < 80) b.kind = ssc_pkg::KIND_SCROLL;
        else if (r < 85) b.kind = ssc_pkg::KIND_WRITE;
        else if (r < 88) b.kind = ssc_pkg::KIND_START;
        else if (r < 92) b.kind = 3'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));
        send_beat(b, 1'b0, '0);
      end
      ph++;
    end

    calm = 1'b0;
    settle();
    $display("Sent %0d beats (%0d directed) over %0d phases with %0d register writes.",
             beats_sent, directed, ph, reg_writes);
    $display("Compared %0d scan beats, %0d mismatches.", scans_seen, mismatches);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
